@@ hw/rtl/utt_pkg.sv @@
// utt_pkg: shared types and constants of the UTF-16 to UTF-8 transcoder.
// No dependencies; imported by the front, queue and back modules.
`default_nettype none

package utt_pkg;

  // Byte order marks as read low byte first
  localparam logic [15:0] BomSwap = 16'hFFFE;
  localparam logic [15:0] BomKeep = 16'hFEFF;

  // Encoding length limits
  localparam logic [15:0] OneByteMax = 16'd127;
  localparam logic [15:0] TwoByteMax = 16'd2047;

  // Lead and continuation prefixes
  localparam logic [7:0] LeadTwo  = 8'b1100_0000;
  localparam logic [7:0] LeadThree = 8'b1110_0000;
  localparam logic [7:0] ContByte = 8'b1000_0000;

  // Work queued from front to back: one code unit or one odd-length error
  typedef struct packed {
    logic        err;
    logic [15:0] code_unit;
  } utt_cmd_t;

  // Handshake between queue and back end
  typedef struct packed {
    logic     valid;
    utt_cmd_t cmd;
  } utt_head_t;

endpackage

`default_nettype wire

@@ hw/rtl/utt_if.sv @@
// utt_if: valid/ready channel interfaces for input bytes and UTF-8 output words.
// No dependencies.
`default_nettype none

interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       odd_length_error;

  modport source (output valid, output out_byte, output last_of_run,
                  output odd_length_error, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input odd_length_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utf16_to_utf8_transcoder_unit.sv @@
// utf16_to_utf8_transcoder_unit: top level of the UTF-16 to UTF-8 transcoder.
// Depends on utt_pkg, utt_if, utt_front, utt_queue and utt_back.
//
// Usage:
//  - in_i carries one raw UTF-16 byte per word (low byte of each unit first),
//    or an end-of-stream word with stream_end set, which carries no byte.
//  - out_o carries one UTF-8 byte per word; last_of_run marks the final word
//    caused by an input word. An end word arriving with a lone pending byte
//    gives one word with odd_length_error set and out_byte zero.
//  - The first unit of a stream is checked for a byte order mark (FFFE swaps,
//    FEFF keeps order); a mark is swallowed. End of stream re-arms that check.
// Timing:
//  - The front accepts one input word per cycle while the command queue has
//    room. The first output word of a completed unit is written into the
//    queue and then into the output register before it is valid on out_o.
//  - The back end emits one output word per cycle while the receiver takes
//    them, so a unit gives 1 to 3 output words.
//  - When the receiver stalls, the output register holds, the queue fills and
//    in_i.ready drops. Reset clears pairing state, queue and output valid.
`default_nettype none

module utf16_to_utf8_transcoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  utt_in_if.sink    in_i,
  utt_out_if.source out_o
);
  import utt_pkg::*;

  logic      push_valid, push_ready, pop;
  utt_cmd_t  push_cmd;
  utt_head_t head;

  utt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_o       (head),
    .pop_i        (pop)
  );

  utt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_byte_o         (out_o.out_byte),
    .last_of_run_o      (out_o.last_of_run),
    .odd_length_error_o (out_o.odd_length_error)
  );

endmodule

`default_nettype wire

@@ hw/rtl/utt_front.sv @@
// utt_front: pairs input bytes into code units, handles the byte order mark,
// and pushes encode or error commands. Depends on utt_pkg.
`default_nettype none

module utt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              stream_end_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output utt_pkg::utt_cmd_t      push_cmd_o
);
  import utt_pkg::*;

  logic       pending_valid_q, pending_valid_d;
  logic [7:0] pending_low_q, pending_low_d;
  logic       first_seen_q, first_seen_d;
  logic       swap_q, swap_d;

  logic        accept;
  logic [15:0] raw_unit;

  // Take a word whenever the queue has room; words without output wait for room too
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign raw_unit   = {data_byte_i, pending_low_q};

  // Pairing, mark detection and swap
  always_comb begin
    pending_valid_d = pending_valid_q;
    pending_low_d   = pending_low_q;
    first_seen_d    = first_seen_q;
    swap_d          = swap_q;
    push_valid_o    = 1'b0;
    push_cmd_o.err  = 1'b0;
    push_cmd_o.code_unit = raw_unit;
    if (accept) begin
      if (stream_end_i) begin
        push_valid_o    = pending_valid_q;
        push_cmd_o.err  = 1'b1;
        push_cmd_o.code_unit = '0;
        pending_valid_d = 1'b0;
        pending_low_d   = '0;
        first_seen_d    = 1'b0;
        swap_d          = 1'b0;
      end else if (!pending_valid_q) begin
        pending_valid_d = 1'b1;
        pending_low_d   = data_byte_i;
      end else begin
        pending_valid_d = 1'b0;
        pending_low_d   = '0;
        if (!first_seen_q) begin
          first_seen_d = 1'b1;
          swap_d       = (raw_unit == BomSwap);
          push_valid_o = (raw_unit != BomSwap) && (raw_unit != BomKeep);
        end else begin
          push_valid_o = 1'b1;
          if (swap_q) begin
            push_cmd_o.code_unit = {pending_low_q, data_byte_i};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_valid_q <= 1'b0;
      pending_low_q   <= '0;
      first_seen_q    <= 1'b0;
      swap_q          <= 1'b0;
    end else begin
      pending_valid_q <= pending_valid_d;
      pending_low_q   <= pending_low_d;
      first_seen_q    <= first_seen_d;
      swap_q          <= swap_d;
    end
  end

  // A push never happens without an accepted word
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> accept)
    else $error("utt_front: push without accepted word");

  // Swap mode only ever set once the first unit has been seen
  a_swap_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swap_q |-> first_seen_q)
    else $error("utt_front: swap set before first unit");

  // An end word always leaves the block in its reset state
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stream_end_i) |=> (!pending_valid_q && !first_seen_q && !swap_q))
    else $error("utt_front: end of stream did not clear state");

endmodule

`default_nettype wire

@@ hw/rtl/utt_queue.sv @@
// utt_queue: small first-in first-out queue of commands between front and back.
// Depends on utt_pkg.
`default_nettype none

module utt_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  utt_pkg::utt_cmd_t      push_cmd_i,
  output utt_pkg::utt_head_t     head_o,
  input  wire logic              pop_i
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  utt_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("utt_queue: fill count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("utt_queue: pop from empty queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("utt_queue: count did not follow push");

endmodule

`default_nettype wire

@@ hw/rtl/utt_back.sv @@
// utt_back: encodes queued code units into 1 to 3 UTF-8 words (an error into one word),
// one per cycle unless stalled, into a registered output stage. Depends on utt_pkg.
`default_nettype none

module utt_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  utt_pkg::utt_head_t     head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o,
  output logic                   odd_length_error_o
);
  import utt_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        last_q, err_q;

  logic [15:0] u;
  logic [1:0]  last_idx;
  logic [7:0]  byte_c;
  logic        last_c;
  logic        load;

  assign u = head_i.cmd.code_unit;

  // Encoded length, as index of the final word
  always_comb begin
    if (head_i.cmd.err || (u <= OneByteMax)) begin
      last_idx = 2'd0;
    end else if (u <= TwoByteMax) begin
      last_idx = 2'd1;
    end else begin
      last_idx = 2'd2;
    end
  end

  // Pick the word at the current position
  always_comb begin
    byte_c = '0;
    case (last_idx)
      2'd0: begin
        byte_c = head_i.cmd.err ? 8'd0 : u[7:0];
      end
      2'd1: begin
        byte_c = (idx_q == 2'd0) ? (LeadTwo | {3'b000, u[10:6]})
                                 : (ContByte | {2'b00, u[5:0]});
      end
      2'd2: begin
        case (idx_q)
          2'd0:    byte_c = LeadThree | {4'b0000, u[15:12]};
          2'd1:    byte_c = ContByte | {2'b00, u[11:6]};
          default: byte_c = ContByte | {2'b00, u[5:0]};
        endcase
      end
      default: byte_c = '0;
    endcase
  end

  assign last_c = (idx_q == last_idx);
  assign load   = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o  = load && last_c;
  assign idx_d  = load ? (last_c ? 2'd0 : idx_q + 2'd1) : idx_q;

  // Output register and position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_c;
      last_q     <= last_c;
      err_q      <= head_i.cmd.err;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign last_of_run_o      = last_q;
  assign odd_length_error_o = err_q;

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (last_q && out_byte_q == 8'd0))
    else $error("utt_back: malformed error word");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("utt_back: position counter out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_byte_q)))
    else $error("utt_back: output changed while stalled");

endmodule

`default_nettype wire
